[sv/mkdr_pkg.sv]
// Shared types, constants and register codes for the multi-key debounce block.
`timescale 1ns / 1ps
package mkdr_pkg;

	// Fixed field widths
	localparam int PIN_W   = 12;
	localparam int CNT_W   = 6;
	localparam int HOLD_W  = 16;
	localparam int KEY_W   = 4;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// Default key count
	localparam int NUM_KEYS_DEF = 12;

	// Register reset values
	localparam logic [CNT_W-1:0]  ON_THRESHOLD_RST = CNT_W'(30);
	localparam logic [HOLD_W-1:0] REPEAT_START_RST = HOLD_W'(250);
	localparam logic [PIN_W-1:0]  SCAN_EN_RST      = PIN_W'(4061);
	localparam logic [PIN_W-1:0]  REPEAT_EN_RST    = PIN_W'(9);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ON_THRESHOLD = 2'd0,
		REG_REPEAT_START = 2'd1,
		REG_SCAN_EN      = 2'd2,
		REG_REPEAT_EN    = 2'd3
	} cfg_reg_t;

	// Input beat
	typedef struct packed {
		logic [PIN_W-1:0] pin_levels;
		logic             repeat_tick;
	} in_beat_t;

	// Result beat
	typedef struct packed {
		logic             push_valid;
		logic [KEY_W-1:0] push_key;
		logic             pull_valid;
		logic [KEY_W-1:0] pull_key;
		logic             repeat_valid;
		logic [KEY_W-1:0] repeat_key;
		logic [PIN_W-1:0] pressed_mask;
	} out_beat_t;

	// Per-lane findings handed to the merge stage
	typedef struct packed {
		logic push_ev;
		logic pull_ev;
		logic rep_ev;
		logic key_on;
	} lane_stat_t;

endpackage

[sv/multi_key_debounce_repeat_top.sv]
// Top level of the multi-key debouncer with hold-repeat detection.
`timescale 1ns / 1ps
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------
//  input    | in_valid / in_stall  | in_data  (in_beat_t)
//  output   | out_valid / out_stall| out_data (out_beat_t)
//  config   | cfg_we               | cfg_index, cfg_data
//
// One beat per clock while in_stall is low; a result is registered in the output
// register, or in the skid entry while the output is held. Every key lane updates
// its counter, on bit and hold count in the accepting cycle.
// The output register has one skid entry: in_stall rises only when both are full.
// Asynchronous reset clears all key state and loads the register defaults.
module multi_key_debounce_repeat_top
	import mkdr_pkg::*;
#(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int LANES = (NUM_KEYS < PIN_W) ? NUM_KEYS : PIN_W;

	logic [CNT_W-1:0]  on_threshold_q;
	logic [HOLD_W-1:0] repeat_start_q;
	logic [PIN_W-1:0]  scan_en_q;
	logic [PIN_W-1:0]  repeat_en_q;
	logic              acc;
	lane_stat_t        stat [LANES];

	assign acc = in_valid && !in_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_threshold_q <= ON_THRESHOLD_RST;
			repeat_start_q <= REPEAT_START_RST;
			scan_en_q      <= SCAN_EN_RST;
			repeat_en_q    <= REPEAT_EN_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ON_THRESHOLD: on_threshold_q <= cfg_data[CNT_W-1:0];
				REG_REPEAT_START: repeat_start_q <= cfg_data[HOLD_W-1:0];
				REG_SCAN_EN:      scan_en_q      <= cfg_data[PIN_W-1:0];
				REG_REPEAT_EN:    repeat_en_q    <= cfg_data[PIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Key lanes
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		mkdr_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.acc          (acc),
			.pin          (in_data.pin_levels[i]),
			.repeat_tick  (in_data.repeat_tick),
			.scan_en      (scan_en_q[i]),
			.repeat_en    (repeat_en_q[i]),
			.on_threshold (on_threshold_q),
			.repeat_start (repeat_start_q),
			.stat         (stat[i])
		);
	end

	// Merge and output buffering
	mkdr_merge #(
		.LANES (LANES)
	) u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.stat      (stat),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.in_stall  (in_stall)
	);

endmodule

[sv/mkdr_lane.sv]
// One key lane: integrating debounce counter, on state and hold-repeat counter.
`timescale 1ns / 1ps
module mkdr_lane
	import mkdr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              acc,
	input  logic              pin,
	input  logic              repeat_tick,
	input  logic              scan_en,
	input  logic              repeat_en,
	input  logic [CNT_W-1:0]  on_threshold,
	input  logic [HOLD_W-1:0] repeat_start,
	output lane_stat_t        stat
);

	logic [CNT_W-1:0]  cnt_q, cnt_n;
	logic              on_q, on_n;
	logic              pmark_q, pmark_n;
	logic [HOLD_W-1:0] hold_q, hold_n;
	logic              push_ev, pull_ev, rep_ev;

	// Debounce then repeat detection, on the freshly updated state
	always_comb begin
		cnt_n   = cnt_q;
		on_n    = on_q;
		pmark_n = pmark_q;
		hold_n  = hold_q;
		push_ev = 1'b0;
		pull_ev = 1'b0;
		rep_ev  = 1'b0;
		if (scan_en) begin
			if (pin) begin
				// released: count down towards zero
				if (cnt_q != '0) cnt_n = cnt_q - CNT_W'(1);
				if (cnt_n == '0) begin
					pmark_n = 1'b0;
					if (on_q) begin
						on_n    = 1'b0;
						pull_ev = 1'b1;
					end
				end
			end else begin
				// pressed: count up, saturating at the threshold
				if (cnt_q < on_threshold) cnt_n = cnt_q + CNT_W'(1);
				if (cnt_n >= on_threshold) begin
					if (!on_q) begin
						on_n    = 1'b1;
						pmark_n = 1'b1;
						push_ev = 1'b1;
					end else begin
						pmark_n = 1'b0;
					end
				end
			end
		end
		if (repeat_tick && repeat_en) begin
			if (on_n && !pmark_n) begin
				hold_n = hold_q + HOLD_W'(1);
				rep_ev = (hold_n == repeat_start);
			end else begin
				hold_n = '0;
			end
		end
	end

	// State update on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			on_q    <= 1'b0;
			pmark_q <= 1'b0;
			hold_q  <= '0;
		end else if (acc) begin
			cnt_q   <= cnt_n;
			on_q    <= on_n;
			pmark_q <= pmark_n;
			hold_q  <= hold_n;
		end
	end

	assign stat.push_ev = push_ev;
	assign stat.pull_ev = pull_ev;
	assign stat.rep_ev  = rep_ev;
	assign stat.key_on  = on_n;

endmodule

[sv/mkdr_merge.sv]
// Merge stage: highest-index pick per event kind, output register and skid entry.
`timescale 1ns / 1ps
module mkdr_merge
	import mkdr_pkg::*;
#(
	parameter int LANES = NUM_KEYS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       acc,
	input  lane_stat_t stat [LANES],
	input  logic       out_stall,
	output logic       out_valid,
	output out_beat_t  out_data,
	output logic       in_stall
);

	out_beat_t res;
	out_beat_t out_q, skid_q;
	logic      out_valid_q, skid_valid_q;

	// Later lanes override earlier ones, so the highest index wins
	always_comb begin
		res = '0;
		for (int i = 0; i < LANES; i++) begin
			if (stat[i].push_ev) begin
				res.push_valid = 1'b1;
				res.push_key   = KEY_W'(i);
			end
			if (stat[i].pull_ev) begin
				res.pull_valid = 1'b1;
				res.pull_key   = KEY_W'(i);
			end
			if (stat[i].rep_ev) begin
				res.repeat_valid = 1'b1;
				res.repeat_key   = KEY_W'(i);
			end
			res.pressed_mask[i] = stat[i].key_on;
		end
	end

	// Output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (acc) out_q <= res;
		end else if (acc) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_stall  = skid_valid_q;

`ifndef SYNTHESIS
	// skid entry only fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a beat taken while the output is held must land in the skid entry
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && acc) |=> skid_valid_q)
		else $error("beat accepted under stall was dropped");

	// a reported push key is shown pressed
	a_push_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.push_valid) |->
		(((out_q.pressed_mask >> out_q.push_key) & PIN_W'(1)) != '0))
		else $error("push key not in pressed mask");

	// a reported pull key is shown released
	a_pull_released: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.pull_valid) |->
		(((out_q.pressed_mask >> out_q.pull_key) & PIN_W'(1)) == '0))
		else $error("pull key still in pressed mask");
`endif

endmodule
